/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL of the column scroller.
// Each macro expects clk and rst_n in scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, idle during reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, idle during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/tbcs_pkg.sv */
// Package for the timed bitmap column scroller: sizes, opcodes, register
// indexes and the item and result beat types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tbcs_pkg;

    localparam int MAX_COLUMNS = 64;
    localparam int MAX_ROWS    = 32;
    localparam int MEM_AW      = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

    localparam int PHASE_W = 20;
    localparam int POS_W   = 17;
    localparam int TIME_W  = 16;
    localparam int DATA_W  = 32;

    localparam logic [PHASE_W-1:0] PHASE_MAX = {PHASE_W{1'b1}};

    // opcodes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;
    localparam logic [1:0] OP_PAUSE = 2'd3;

    // register indexes
    localparam logic [1:0] CFG_COLUMNS_USED = 2'd0;
    localparam logic [1:0] CFG_ROWS_USED    = 2'd1;
    localparam logic [1:0] CFG_WAIT_FRAMES  = 2'd2;
    localparam logic [1:0] CFG_FRAME_PERIOD = 2'd3;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [TIME_W-1:0] delta;
        logic [5:0]        column_index;
        logic [DATA_W-1:0] column_bits;
        logic [TIME_W-1:0] start_delay;
    } item_t;

    typedef struct packed {
        logic              frame_valid;
        logic [DATA_W-1:0] column_out;
        logic              running;
        logic              stopped_now;
    } result_t;

endpackage

`default_nettype wire

/* hdl/timed_bitmap_column_scroller.sv */
// Top level of the timed bitmap column scroller: control, bitmap memory
// and result register. Depends on tbcs_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

// Every accepted item gives exactly one result beat, registered at the accept
// edge; an item can be accepted in every cycle while item_stall is low. Timing
// state (delay, phase accumulator, column position) is updated at the accept
// edge; in the same edge the bitmap memory (MAX_COLUMNS x 32, one write and one
// registered read port) is read at the current position into the result
// register, so the result side only masks the read word. item_stall rises
// only while a result beat waits and result_stall is high. Configuration
// writes are taken in any cycle (cfg_ready is always high) and are meant to
// happen while the block is idle. Bitmap columns read before being loaded
// give undefined row bits.

`include "assert_macros.svh"

module timed_bitmap_column_scroller
    import tbcs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire item_t       item,
    output logic             result_valid,
    input  wire logic        result_stall,
    output result_t          result,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    logic [6:0]         columns_used_reg;
    logic [5:0]         rows_used_reg;
    logic [TIME_W-1:0]  wait_frames_reg;
    logic [TIME_W-1:0]  frame_period_reg;

    logic               enabled_reg, enabled_next;
    logic [TIME_W-1:0]  delay_left_reg, delay_left_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [POS_W-1:0]   pos_reg, pos_next;

    logic               result_valid_reg;
    logic               frame_reg, frame_next;
    logic               stopped_reg, stopped_next;
    logic [DATA_W-1:0]  mask_reg, mask_next;
    logic [DATA_W-1:0]  rd_data_reg;

    logic [DATA_W-1:0]  bitmap_mem [MAX_COLUMNS];

    logic               accept;
    logic               is_tick;
    logic [PHASE_W:0]   phase_sum;
    logic [PHASE_W-1:0] phase_sat;
    logic [PHASE_W-1:0] phase_left;
    logic               frame_due;
    logic [POS_W-1:0]   pos_inc;
    logic [POS_W-1:0]   total_frames;
    logic               col_in_range;
    logic [6:0]         rows_eff;
    logic [DATA_W-1:0]  row_mask;

    assign cfg_ready  = 1'b1;
    assign item_stall = result_valid_reg && result_stall;
    assign accept     = item_valid && !item_stall;
    assign is_tick    = (item.opcode == OP_TICK);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_used_reg <= 7'd1;
            rows_used_reg    <= 6'd1;
            wait_frames_reg  <= '0;
            frame_period_reg <= TIME_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_COLUMNS_USED: columns_used_reg <= cfg_data[6:0];
                CFG_ROWS_USED:    rows_used_reg    <= cfg_data[5:0];
                CFG_WAIT_FRAMES:  wait_frames_reg  <= cfg_data;
                CFG_FRAME_PERIOD: frame_period_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // row mask: low min(rows_used, MAX_ROWS, 32) bits
    always_comb
    begin
        rows_eff = {1'b0, rows_used_reg};
        if (32'(rows_eff) > MAX_ROWS)
            rows_eff = 7'(MAX_ROWS);
        if (rows_eff >= 7'(DATA_W))
            row_mask = '1;
        else
            row_mask = (DATA_W'(1) << rows_eff[4:0]) - DATA_W'(1);
    end

    // tick arithmetic
    assign phase_sum    = {1'b0, phase_reg} + (PHASE_W + 1)'(item.delta);
    assign phase_sat    = phase_sum[PHASE_W] ? PHASE_MAX : phase_sum[PHASE_W-1:0];
    assign frame_due    = (phase_sat >= PHASE_W'(frame_period_reg));
    assign phase_left   = phase_sat - PHASE_W'(frame_period_reg);
    assign pos_inc      = pos_reg + POS_W'(1);
    assign total_frames = POS_W'(columns_used_reg) + POS_W'(wait_frames_reg);
    assign col_in_range = (pos_reg < POS_W'(columns_used_reg))
                       && (32'(pos_reg) < MAX_COLUMNS);

    always_comb
    begin
        enabled_next    = enabled_reg;
        delay_left_next = delay_left_reg;
        phase_next      = phase_reg;
        pos_next        = pos_reg;
        frame_next      = 1'b0;
        stopped_next    = 1'b0;
        mask_next       = '0;
        case (item.opcode)
            OP_START:
            begin
                enabled_next    = 1'b1;
                delay_left_next = item.start_delay;
            end
            OP_PAUSE:
            begin
                enabled_next = 1'b0;
            end
            OP_TICK:
            begin
                if (enabled_reg)
                begin
                    if (delay_left_reg != '0)
                    begin
                        // count the delay down, drop leftover time
                        if (item.delta >= delay_left_reg)
                            delay_left_next = '0;
                        else
                            delay_left_next = delay_left_reg - item.delta;
                    end
                    else if (!frame_due)
                    begin
                        phase_next = phase_sat;
                    end
                    else
                    begin
                        frame_next = 1'b1;
                        mask_next  = col_in_range ? row_mask : '0;
                        if (total_frames <= pos_inc)
                        begin
                            enabled_next = 1'b0;
                            pos_next     = '0;
                            phase_next   = '0;
                            stopped_next = 1'b1;
                        end
                        else
                        begin
                            pos_next   = pos_inc;
                            phase_next = phase_left;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg      <= 1'b0;
            delay_left_reg   <= '0;
            phase_reg        <= '0;
            pos_reg          <= '0;
            result_valid_reg <= 1'b0;
            frame_reg        <= 1'b0;
            stopped_reg      <= 1'b0;
            mask_reg         <= '0;
        end
        else
        begin
            if (accept)
            begin
                enabled_reg    <= enabled_next;
                delay_left_reg <= delay_left_next;
                phase_reg      <= phase_next;
                pos_reg        <= pos_next;
                frame_reg      <= frame_next;
                stopped_reg    <= stopped_next;
                mask_reg       <= mask_next;
            end
            // hold the beat while stalled, load a new one on accept
            if (accept)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    // bitmap memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (accept && item.opcode == OP_LOAD && 32'(item.column_index) < MAX_COLUMNS)
            bitmap_mem[MEM_AW'(item.column_index)] <= item.column_bits;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            rd_data_reg <= bitmap_mem[MEM_AW'(pos_reg)];
    end

    assign result_valid       = result_valid_reg;
    assign result.frame_valid = frame_reg;
    assign result.column_out  = rd_data_reg & mask_reg;
    assign result.running     = enabled_reg;
    assign result.stopped_now = stopped_reg;

    `ASSERT_IMPL(a_stop_clears_run, result_valid_reg && stopped_reg,
        frame_reg && !enabled_reg, "stop beat must carry a frame and clear running")
    `ASSERT_IMPL(a_blank_without_frame, !frame_reg,
        mask_reg == '0, "row bits shown without a frame")
    `ASSERT_NEXT(a_delay_blocks_frame,
        accept && is_tick && delay_left_reg != '0,
        !frame_reg, "frame emitted while the start delay was pending")
    `ASSERT_NEXT(a_stop_rewinds, accept && stopped_next,
        pos_reg == '0 && phase_reg == '0, "position not rewound after stop")

endmodule

`default_nettype wire

/* tb/timed_bitmap_column_scroller_test.sv */
// Self-checking testbench for the timed bitmap column scroller: a frame
// predictor in a small scoreboard class, plus tasks that drive items and
// register writes. Depends on tbcs_pkg and the timed_bitmap_column_scroller RTL.
`timescale 1ns / 1ps

module timed_bitmap_column_scroller_test;
    import tbcs_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TOTAL_ITEMS    = 1100;

    // Predicts the frame beat of every accepted item and checks the beats.
    class frame_checker;
        logic [6:0]        columns_used;
        logic [5:0]        rows_used;
        logic [15:0]       wait_frames;
        logic [15:0]       frame_period;
        bit                enabled;
        logic [15:0]       delay_left;
        logic [19:0]       phase_time;
        logic [16:0]       column_pos;
        logic [DATA_W-1:0] bitmap [MAX_COLUMNS];
        result_t           expected_frames [$];
        int                errors;
        int                frames_seen;
        int                stops_seen;

        function new();
            columns_used = 7'd1;
            rows_used    = 6'd1;
            wait_frames  = 16'd0;
            frame_period = 16'd1;
            enabled      = 1'b0;
            delay_left   = '0;
            phase_time   = '0;
            column_pos   = '0;
            errors       = 0;
            frames_seen  = 0;
            stops_seen   = 0;
            for (int i = 0; i < MAX_COLUMNS; i++)
                bitmap[i] = '0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] value);
            case (idx)
                CFG_COLUMNS_USED: columns_used = value[6:0];
                CFG_ROWS_USED:    rows_used    = value[5:0];
                CFG_WAIT_FRAMES:  wait_frames  = value;
                CFG_FRAME_PERIOD: frame_period = value;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction

        function void note_item(item_t it);
            result_t     want;
            logic [20:0] sum;
            int          rows;
            logic [31:0] mask;
            want = '0;
            case (it.opcode)
                OP_LOAD:
                begin
                    if (it.column_index < MAX_COLUMNS)
                        bitmap[it.column_index] = it.column_bits;
                end
                OP_START:
                begin
                    enabled    = 1'b1;
                    delay_left = it.start_delay;
                end
                OP_PAUSE: enabled = 1'b0;
                default:
                begin
                    if (enabled && delay_left != 0)
                    begin
                        // leftover time after the delay is dropped
                        delay_left = (it.delta >= delay_left) ? 16'd0 : delay_left - it.delta;
                    end
                    else if (enabled)
                    begin
                        sum = {1'b0, phase_time} + {5'd0, it.delta};
                        phase_time = (sum > {1'b0, PHASE_MAX}) ? PHASE_MAX : sum[19:0];
                        if (phase_time >= {4'd0, frame_period})
                        begin
                            want.frame_valid = 1'b1;
                            rows = (rows_used > MAX_ROWS) ? MAX_ROWS : int'(rows_used);
                            mask = (rows >= 32) ? 32'hFFFF_FFFF : (32'd1 << rows) - 32'd1;
                            if (column_pos < {10'd0, columns_used} && column_pos < MAX_COLUMNS)
                                want.column_out = bitmap[column_pos[5:0]] & mask;
                            column_pos = column_pos + 17'd1;
                            phase_time = phase_time - {4'd0, frame_period};
                            if (int'(columns_used) + int'(wait_frames) <= int'(column_pos))
                            begin
                                enabled     = 1'b0;
                                column_pos  = '0;
                                phase_time  = '0;
                                want.stopped_now = 1'b1;
                            end
                        end
                    end
                end
            endcase
            want.running = enabled;
            if (want.frame_valid)
                frames_seen++;
            if (want.stopped_now)
                stops_seen++;
            expected_frames.push_back(want);
        endfunction

        function void check_frame(result_t got);
            result_t want;
            if (expected_frames.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: result beat with nothing expected: %s%h %s%0b %s%0b",
                             "col=", got.column_out, "fv=", got.frame_valid,
                             "run/stop=", {got.running, got.stopped_now});
                return;
            end
            want = expected_frames.pop_front();
            if (got.frame_valid !== want.frame_valid || got.column_out !== want.column_out ||
                got.running !== want.running || got.stopped_now !== want.stopped_now)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("ERROR at %0t: expected fv=%0b col=%h run=%0b stop=%0b",
                             $realtime, want.frame_valid, want.column_out, want.running,
                             want.stopped_now);
                    $display("              got      fv=%0b col=%h run=%0b stop=%0b",
                             got.frame_valid, got.column_out, got.running,
                             got.stopped_now);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    item_t       item;
    logic        result_valid;
    logic        result_stall;
    result_t     result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    frame_checker sb;
    int           burst_left;
    int           busy_items;
    int           items_sent;
    int           settings_seen;
    int           idle_cycles;
    int           stall_left;
    int           stall_mode;

    timed_bitmap_column_scroller dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        result_stall = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_COLUMNS_USED;
        cfg_data     = '0;
        idle_cycles  = 0;
        stall_left   = 0;
        stall_mode   = 0;
    end

    always
    begin
        #5 clk = ~clk;
    end

    // Receiver: stall on a pattern that changes mode when its countdown runs out.
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 200);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0: result_stall <= 1'b0;
            1: result_stall <= ($urandom_range(0, 3) == 0);
            2: result_stall <= ($urandom_range(0, 3) != 0);
            default: result_stall <= ((stall_left % 16) < 6);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_frame(result);
    end

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no beat moved for %0d cycles", idle_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic item_t make_item(logic [1:0] op, logic [15:0] delta,
                                        logic [15:0] sdelay);
        item_t       it;
        logic [31:0] r;
        r = $urandom;
        it.opcode       = op;
        it.delta        = delta;
        it.column_index = r[5:0];
        it.column_bits  = $urandom;
        it.start_delay  = sdelay;
        return it;
    endfunction

    function automatic logic [15:0] pick_delta(logic [15:0] period);
        logic [31:0] r;
        logic [31:0] v;
        r = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = {16'd0, period};
            4, 5: v = r % ({16'd0, period} + 32'd1);
            6: v = 32'd0;
            7: v = 32'h0000_FFFF;
            default: v = r;
        endcase
        return v[15:0];
    endfunction

    function automatic logic [15:0] pick_delay(logic [15:0] period);
        logic [31:0] r;
        logic [31:0] v;
        r = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = 32'd0;
            5, 6, 7: v = r % ({15'd0, period, 1'b0} + 32'd3);
            8: v = 32'h0000_FFFF;
            default: v = r;
        endcase
        return v[15:0];
    endfunction

    // Mostly ticks that keep an animation moving, with restarts, pauses and loads.
    function automatic item_t next_scripted();
        item_t it;
        int    pick;
        it = make_item(OP_TICK, pick_delta(sb.frame_period), pick_delay(sb.frame_period));
        pick = $urandom_range(0, 99);
        if (!sb.enabled)
        begin
            if (pick < 70)
                it.opcode = OP_START;
        end
        else if (pick < 4)
            it.opcode = OP_START;
        else if (pick < 8)
            it.opcode = OP_PAUSE;
        else if (pick < 15)
            it.opcode = OP_LOAD;
        return it;
    endfunction

    task automatic send_item(input item_t it);
        if (burst_left == 0)
        begin
            @(negedge clk);
            item_valid <= 1'b0;
            if ($urandom_range(0, 9) == 0)
            begin
                // hold off until every frame beat is back
                while (sb.pending() != 0)
                    @(posedge clk);
            end
            repeat ($urandom_range(0, 11)) @(negedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? 120 : $urandom_range(1, 24);
        end
        @(negedge clk);
        item_valid <= 1'b1;
        item       <= it;
        do @(posedge clk); while (item_stall);
        sb.note_item(it);
        burst_left--;
        items_sent++;
    endtask

    task automatic settle();
        @(negedge clk);
        item_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_setting(input logic [15:0] columns, input logic [15:0] rows,
                                 input logic [15:0] waits, input logic [15:0] period);
        settle();
        write_reg(CFG_COLUMNS_USED, columns);
        write_reg(CFG_ROWS_USED, rows);
        write_reg(CFG_WAIT_FRAMES, waits);
        write_reg(CFG_FRAME_PERIOD, period);
        settings_seen++;
    endtask

    task automatic random_setting();
        logic [31:0] r;
        logic [15:0] columns;
        logic [15:0] rows;
        logic [15:0] waits;
        logic [15:0] period;
        r = $urandom;
        case ($urandom_range(0, 9))
            0: columns = 16'd0;
            1: columns = 16'd1;
            2: columns = 16'd64;
            3: columns = 16'd66;
            4: columns = 16'd127;
            default: columns = 16'd1 + {13'd0, r[2:0]};
        endcase
        case ($urandom_range(0, 6))
            0: rows = 16'd0;
            1: rows = 16'd1;
            2: rows = 16'd32;
            3: rows = 16'd63;
            default: rows = 16'd1 + {11'd0, r[7:3]};
        endcase
        case ($urandom_range(0, 6))
            0: waits = 16'd0;
            1: waits = 16'hFFFF;
            default: waits = {13'd0, r[10:8]};
        endcase
        case ($urandom_range(0, 7))
            0: period = 16'd0;
            1: period = 16'd1;
            2: period = 16'hFFFF;
            3, 4: period = 16'd1 + {8'd0, r[18:11]};
            default: period = 16'd1 + {13'd0, r[21:19]};
        endcase
        write_setting(columns, rows, waits, period);
    endtask

    // Load every column so that no playback ever reads an unloaded one.
    task automatic fill_bitmap();
        item_t it;
        for (int i = 0; i < MAX_COLUMNS; i++)
        begin
            it = make_item(OP_LOAD, 16'd0, 16'd0);
            it.column_index = 6'(i);
            if (i == 0)
                it.column_bits = 32'hFFFF_FFFF;
            else if (i == 1)
                it.column_bits = 32'hA5A5_5A5A;
            send_item(it);
        end
    endtask

    task automatic directed_items();
        item_t it;
        write_setting(16'd3, 16'd32, 16'd2, 16'd4);
        send_item(make_item(OP_TICK, 16'hFFFF, 16'd0));   // disabled: no effect
        send_item(make_item(OP_START, 16'hFFFF, 16'd5));
        send_item(make_item(OP_TICK, 16'd3, 16'hFFFF));   // delay counts down
        send_item(make_item(OP_TICK, 16'hFFFF, 16'd0));   // delay ends, excess dropped
        send_item(make_item(OP_TICK, 16'd4, 16'd0));
        send_item(make_item(OP_TICK, 16'd0, 16'd0));
        send_item(make_item(OP_TICK, 16'hFFFF, 16'd0));   // excess stays in phase
        send_item(make_item(OP_START, 16'd0, 16'd0));     // restart keeps position
        send_item(make_item(OP_TICK, 16'd0, 16'd0));
        send_item(make_item(OP_TICK, 16'd0, 16'd0));      // blank wait frames
        send_item(make_item(OP_TICK, 16'd0, 16'd0));
        send_item(make_item(OP_TICK, 16'hFFFF, 16'd0));
        send_item(make_item(OP_START, 16'd0, 16'hFFFF));
        send_item(make_item(OP_PAUSE, 16'hFFFF, 16'hFFFF));
        send_item(make_item(OP_TICK, 16'hFFFF, 16'd0));
        it = make_item(OP_LOAD, 16'hFFFF, 16'hFFFF);
        it.column_index = 6'd63;
        it.column_bits  = 32'd0;
        send_item(it);
        send_item(make_item(OP_START, 16'd0, 16'd0));
        send_item(make_item(OP_TICK, 16'd4, 16'd0));
        // no columns and no wait frames: one blank frame, which also stops
        write_setting(16'd0, 16'd0, 16'd0, 16'd0);
        send_item(make_item(OP_START, 16'd0, 16'd0));
        send_item(make_item(OP_TICK, 16'd0, 16'd0));
        write_setting(16'd64, 16'd63, 16'd1, 16'd1);
        send_item(make_item(OP_START, 16'd0, 16'd0));
        send_item(make_item(OP_TICK, 16'hFFFF, 16'd0));
        send_item(make_item(OP_TICK, 16'hFFFF, 16'd0));
        send_item(make_item(OP_TICK, 16'd0, 16'd0));
    endtask

    initial
    begin
        item_t it;
        int    n;
        bit    noisy;
        sb            = new();
        burst_left    = 0;
        busy_items    = 0;
        items_sent    = 0;
        settings_seen = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        fill_bitmap();
        directed_items();

        while (items_sent < TOTAL_ITEMS)
        begin
            random_setting();
            noisy = ($urandom_range(0, 4) == 0);
            n = $urandom_range(30, 90);
            for (int i = 0; i < n && items_sent < TOTAL_ITEMS; i++)
            begin
                if (noisy)
                    it = make_item(2'($urandom_range(0, 3)), pick_delta(sb.frame_period),
                                   pick_delay(sb.frame_period));
                else
                    it = next_scripted();
                if (!(it.opcode == OP_TICK && !sb.enabled))
                    busy_items++;
                send_item(it);
            end
        end

        settle();
        repeat (5) @(posedge clk);
        $display("Run covered %0d items, %0d of them active, under %0d register settings",
                 items_sent, busy_items, settings_seen);
        $display("Predicted %0d frames and %0d finished animations", sb.frames_seen,
                 sb.stops_seen);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
        begin
            $display("%0d mismatches, %0d frame beats never arrived", sb.errors, sb.pending());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
